/* sv/kmd_pkg.sv */
package kmd_pkg;

    localparam int Pins        = 10;
    localparam int Cols        = Pins - 1;
    localparam int Keys        = Pins * Cols;
    localparam int MaxEvents   = 8;
    localparam int KeycodeBits = 16;
    localparam int AddrW       = $clog2(Keys);
    localparam int CntW        = $clog2(MaxEvents + 1);
    localparam int FrameW      = 3;

    localparam logic [FrameW-1:0] ArmFrames = FrameW'(2);

    typedef struct packed {
        logic        scan_start;
        logic [3:0]  row;
        logic [3:0]  column;
        logic        pressed;
        logic [15:0] keycode;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  event_row;
        logic [3:0]  event_column;
        logic        event_pressed;
        logic [15:0] event_keycode;
    } t_out_item;

    typedef struct packed {
        logic                   state;
        logic                   pending;
        logic [FrameW-1:0]      frame;
        logic [KeycodeBits-1:0] code;
    } t_key_entry;

    typedef struct packed {
        logic                   evt;
        t_key_entry             entry;
        logic [KeycodeBits-1:0] evt_code;
        logic [CntW-1:0]        cnt;
    } t_key_upd;

endpackage

/* sv/kmd_key_ram.sv */
module kmd_key_ram (
    input  logic                     i_clk,
    input  logic                     i_rd_en,
    input  logic [kmd_pkg::AddrW-1:0] i_rd_addr,
    output kmd_pkg::t_key_entry      o_rd_data,
    input  logic                     i_wr_en,
    input  logic [kmd_pkg::AddrW-1:0] i_wr_addr,
    input  kmd_pkg::t_key_entry      i_wr_data
);

    kmd_pkg::t_key_entry r_mem [kmd_pkg::Keys];
    kmd_pkg::t_key_entry r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read-before-write: a same-edge write is forwarded by the caller
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* sv/kmd_key_update.sv */
module kmd_key_update (
    input  kmd_pkg::t_key_entry                  i_entry,
    input  logic                                 i_in_range,
    input  logic                                 i_scan_start,
    input  logic                                 i_pressed,
    input  logic [kmd_pkg::KeycodeBits-1:0]      i_keycode,
    input  logic [kmd_pkg::CntW-1:0]             i_events,
    output kmd_pkg::t_key_upd                    o_upd
);

    logic [kmd_pkg::CntW-1:0] cnt;

    always_comb begin
        cnt            = i_scan_start ? '0 : i_events;
        o_upd.evt      = 1'b0;
        o_upd.entry    = i_entry;
        o_upd.evt_code = i_keycode;
        o_upd.cnt      = cnt;
        if (i_in_range) begin
            if (i_entry.frame > kmd_pkg::FrameW'(1)) begin
                o_upd.entry.frame = i_entry.frame - kmd_pkg::FrameW'(1);
            end else if (i_entry.frame == kmd_pkg::FrameW'(1)) begin
                // full event budget: leave the key armed for the next scan
                if (cnt < kmd_pkg::CntW'(kmd_pkg::MaxEvents)) begin
                    o_upd.entry.frame = '0;
                    if (i_entry.pending == i_pressed) begin
                        o_upd.entry.state = i_pressed;
                        if (i_pressed) begin
                            o_upd.entry.code = i_keycode;
                        end else begin
                            o_upd.evt_code = i_entry.code;
                        end
                        if (o_upd.evt_code != '0) begin
                            o_upd.evt = 1'b1;
                            o_upd.cnt = cnt + kmd_pkg::CntW'(1);
                        end
                    end
                end
            end else if (i_entry.state != i_pressed) begin
                o_upd.entry.pending = i_pressed;
                o_upd.entry.frame   = kmd_pkg::ArmFrames;
            end
        end
    end

endmodule

/* sv/key_matrix_debounce_events_top.sv */
// Per-key debounce of a scanned key matrix. One key sample is taken per clock unless
// stalled; a press or release event passes the read stage, then the output register.
// The per-key table is a one-port-read, one-port-write memory: the entry is read at
// accept and written back as it leaves the read stage, with the just-written
// entry forwarded when the following sample hits the same key, so back-to-back
// samples keep full rate. Reset takes effect at once through per-entry valid flags
// (no clearing pass). The input stalls only while an event is held in the output
// register and the downstream side stalls with the next sample in the read stage.
module key_matrix_debounce_events_top (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  kmd_pkg::t_in_item    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output kmd_pkg::t_out_item   o_out
);

    logic                        in_accept;
    logic                        in_range;
    logic [kmd_pkg::AddrW-1:0]   in_addr;
    logic                        s1_go;
    logic                        wr_en;
    logic                        fwd_hit;
    kmd_pkg::t_key_entry         rd_entry;
    kmd_pkg::t_key_entry         cur_entry;
    kmd_pkg::t_key_upd           upd;

    logic                        r_s1_valid;
    kmd_pkg::t_in_item           r_s1_item;
    logic                        r_s1_in_range;
    logic [kmd_pkg::AddrW-1:0]   r_s1_addr;
    logic                        r_fwd;
    kmd_pkg::t_key_entry         r_fwd_entry;
    logic                        r_rd_vld;
    logic [kmd_pkg::Keys-1:0]    r_key_vld;
    logic [kmd_pkg::CntW-1:0]    r_events;
    logic                        r_out_valid;
    kmd_pkg::t_out_item          r_out;

    assign in_range = (int'(i_in.row) < kmd_pkg::Pins) && (int'(i_in.column) < kmd_pkg::Cols);
    assign in_addr  = in_range ?
        kmd_pkg::AddrW'(int'(i_in.row) * kmd_pkg::Cols + int'(i_in.column)) : '0;

    assign s1_go      = r_s1_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_s1_valid && !s1_go;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign wr_en      = s1_go && r_s1_in_range;
    assign fwd_hit    = wr_en && (r_s1_addr == in_addr);

    kmd_key_ram u_ram (
        .i_clk     (i_clk),
        .i_rd_en   (in_accept),
        .i_rd_addr (in_addr),
        .o_rd_data (rd_entry),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (upd.entry)
    );

    always_comb begin
        if (r_fwd) begin
            cur_entry = r_fwd_entry;
        end else if (r_rd_vld) begin
            cur_entry = rd_entry;
        end else begin
            cur_entry = '0;
        end
    end

    kmd_key_update u_upd (
        .i_entry      (cur_entry),
        .i_in_range   (r_s1_in_range),
        .i_scan_start (r_s1_item.scan_start),
        .i_pressed    (r_s1_item.pressed),
        .i_keycode    (r_s1_item.keycode[kmd_pkg::KeycodeBits-1:0]),
        .i_events     (r_events),
        .o_upd        (upd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_key_vld   <= '0;
            r_events    <= '0;
            r_out_valid <= 1'b0;
            r_fwd       <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
                r_fwd      <= fwd_hit;
            end else if (s1_go) begin
                r_s1_valid <= 1'b0;
            end
            if (wr_en) begin
                r_key_vld[r_s1_addr] <= 1'b1;
            end
            if (s1_go) begin
                r_events <= upd.cnt;
            end
            if (s1_go && upd.evt) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_item     <= i_in;
            r_s1_in_range <= in_range;
            r_s1_addr     <= in_addr;
            r_fwd_entry   <= upd.entry;
            r_rd_vld      <= r_key_vld[in_addr];
        end
        if (s1_go && upd.evt) begin
            r_out.event_row     <= r_s1_item.row;
            r_out.event_column  <= r_s1_item.column;
            r_out.event_pressed <= r_s1_item.pressed;
            r_out.event_keycode <= 16'(upd.evt_code);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // event budget per scan is never exceeded
    a_events_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_events <= kmd_pkg::CntW'(kmd_pkg::MaxEvents))
        else $error("event count above budget");

    // an event beat never carries keycode zero
    a_evt_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.event_keycode != '0))
        else $error("event with empty keycode");

    // forwarding only follows a write-back in the accept cycle
    a_fwd_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_fwd == $past(fwd_hit)))
        else $error("forward flag mismatch");

    // an event only comes from a key in its final wait frame
    a_evt_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_go && upd.evt) |-> (cur_entry.frame == kmd_pkg::FrameW'(1) && r_s1_in_range))
        else $error("event outside final frame");

    // input stalls only while the output register is held
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_s1_valid))
        else $error("input stalled without cause");

endmodule
